/* rtl/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue core
// Store geometry, operation codes, control structs and ring index helpers.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Store geometry.
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SIZE       = 3'd4;
  localparam logic [OP_W-1:0] OP_EMPTY      = 3'd5;
  localparam logic [OP_W-1:0] OP_FRONT      = 3'd6;
  localparam logic [OP_W-1:0] OP_BACK       = 3'd7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Access to the entry store issued by the controller.
  typedef struct packed {
    logic                     wr_en;
    logic                     rd_en;
    idx_t                     addr;
    logic signed [DATA_W-1:0] wdata;
  } mem_req_t;

  // Registered result of one request, aligned with the store read data.
  typedef struct packed {
    logic                     valid;
    logic                     from_mem;
    logic signed [DATA_W-1:0] value;
    logic                     no_item;
    logic                     push_dropped;
  } res_info_t;

  // Ring index base + off, where off is at most DEPTH - 1.
  function automatic idx_t wrap_add(input idx_t base, input cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/dq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram: single-port synchronous RAM
// One access per cycle at one address; read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read at the same address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/dq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl: pointer and count control for the deque
// Decodes the request, issues at most one store access and updates head and count.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic [dq_pkg::OP_W-1:0]         op,
  input  wire logic signed [dq_pkg::DATA_W-1:0] push_value,
  output dq_pkg::mem_req_t                     mem_req,
  output dq_pkg::res_info_t                    res_info
);

  dq_pkg::idx_t      head;
  dq_pkg::idx_t      head_next;
  dq_pkg::cnt_t      count;
  dq_pkg::cnt_t      count_next;
  dq_pkg::res_info_t res_next;
  logic              is_empty;
  logic              is_full;
  dq_pkg::idx_t      head_prev;
  dq_pkg::idx_t      head_inc;
  dq_pkg::idx_t      back_slot;
  dq_pkg::idx_t      tail_slot;

  assign is_empty  = (count == '0);
  assign is_full   = (count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign head_prev = (head == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : head - 1'b1;
  assign head_inc  = (head == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
  // The back entry sits count - 1 past the head; a push at the back lands at count.
  assign back_slot = dq_pkg::wrap_add(head, count - 1'b1);
  assign tail_slot = dq_pkg::wrap_add(head, count);

  // Decode the request into a store access, new pointers and the result word.
  always_comb begin
    mem_req.wr_en        = 1'b0;
    mem_req.rd_en        = 1'b0;
    mem_req.addr         = head;
    mem_req.wdata        = push_value;
    head_next            = head;
    count_next           = count;
    res_next.valid       = accept;
    res_next.from_mem    = 1'b0;
    res_next.value       = '0;
    res_next.no_item     = 1'b0;
    res_next.push_dropped = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          res_next.push_dropped = 1'b1;
        end else begin
          mem_req.wr_en = accept;
          mem_req.addr  = head_prev;
          head_next     = head_prev;
          count_next    = count + 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          res_next.push_dropped = 1'b1;
        end else begin
          mem_req.wr_en = accept;
          mem_req.addr  = tail_slot;
          count_next    = count + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          res_next.no_item = 1'b1;
        end else begin
          mem_req.rd_en     = accept;
          res_next.from_mem = 1'b1;
          head_next         = head_inc;
          count_next        = count - 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          res_next.no_item = 1'b1;
        end else begin
          mem_req.rd_en     = accept;
          mem_req.addr      = back_slot;
          res_next.from_mem = 1'b1;
          count_next        = count - 1'b1;
        end
      end
      dq_pkg::OP_SIZE: begin
        res_next.value = dq_pkg::DATA_W'(count);
      end
      dq_pkg::OP_EMPTY: begin
        res_next.value = dq_pkg::DATA_W'(is_empty);
      end
      dq_pkg::OP_FRONT: begin
        if (is_empty) begin
          res_next.no_item = 1'b1;
        end else begin
          mem_req.rd_en     = accept;
          res_next.from_mem = 1'b1;
        end
      end
      dq_pkg::OP_BACK: begin
        if (is_empty) begin
          res_next.no_item = 1'b1;
        end else begin
          mem_req.rd_en     = accept;
          mem_req.addr      = back_slot;
          res_next.from_mem = 1'b1;
        end
      end
      default: begin
        res_next.valid = accept;
      end
    endcase
  end

  // Pointer state updates only on an accepted word; the result payload
  // is registered alongside the store read.
  always_ff @(posedge clk) begin
    res_info.from_mem     <= res_next.from_mem;
    res_info.value        <= res_next.value;
    res_info.no_item      <= res_next.no_item;
    res_info.push_dropped <= res_next.push_dropped;
    if (rst) begin
      head           <= '0;
      count          <= '0;
      res_info.valid <= 1'b0;
    end else begin
      res_info.valid <= res_next.valid;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/double_ended_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// The result word appears in the cycle after its request is accepted.
// Throughput: one request per cycle; each request makes at most one store access
// in the accept cycle, and stored words come back through the store's registered read.
// busy stays low, so start may be held high every cycle.
// Reset (rst, synchronous) empties the deque; store contents are not cleared.
// The receiver cannot stall: result_valid marks each result for one cycle.
// ----------------------------------------------------------------------------
// double_ended_queue_core: deque of signed 32-bit words in a ring store
// Push, pop and peek at either end, plus size and empty queries.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dq_pkg::OP_W-1:0]          op,
  input  wire logic signed [dq_pkg::DATA_W-1:0] push_value,
  output logic                                  result_valid,
  output logic signed [dq_pkg::DATA_W-1:0]      result_value,
  output logic                                  no_item,
  output logic                                  push_dropped
);

  logic                      accept;
  dq_pkg::mem_req_t          mem_req;
  dq_pkg::res_info_t         res_info;
  logic [dq_pkg::DATA_W-1:0] rdata;

  // Every request finishes its store access in its accept cycle, so none waits.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .push_value (push_value),
    .mem_req    (mem_req),
    .res_info   (res_info)
  );

  dq_ram #(
    .DATA_W (dq_pkg::DATA_W),
    .DEPTH  (dq_pkg::DEPTH),
    .ADDR_W (dq_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .wr_en (mem_req.wr_en),
    .rd_en (mem_req.rd_en),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Select the stored word for pops and peeks, else the computed word.
  assign result_valid = res_info.valid;
  assign result_value = res_info.from_mem ? $signed(rdata) : res_info.value;
  assign no_item      = res_info.no_item;
  assign push_dropped = res_info.push_dropped;

endmodule
`default_nettype wire

/* tb/tb_double_ended_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core: self-checking bench for the deque core
// A directed opening covers both ends on an empty and a loaded deque and the
// extreme words. Random traffic then fills the ring to full, pushes into it,
// and drains it. A shadow deque predicts every result word. A clocked monitor
// compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;

  localparam int RANDOM_REQS = 1700;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [dq_pkg::OP_W-1:0]          code;
    logic signed [dq_pkg::DATA_W-1:0] word;
    int unsigned                      gap;
    bit                               settle;
  } deque_request_t;

  typedef struct packed {
    logic signed [dq_pkg::DATA_W-1:0] value;
    logic                             no_item;
    logic                             push_dropped;
  } deque_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic [dq_pkg::OP_W-1:0]          op = dq_pkg::OP_SIZE;
  logic signed [dq_pkg::DATA_W-1:0] push_value = '0;
  logic                             busy;
  logic                             result_valid;
  logic signed [dq_pkg::DATA_W-1:0] result_value;
  logic                             no_item;
  logic                             push_dropped;

  deque_request_t request_queue[$];
  deque_result_t  expected_results[$];
  int unsigned    mismatch_count = 0;

  // Shadow copy of the deque contents.
  logic signed [dq_pkg::DATA_W-1:0] shadow_store [dq_pkg::DEPTH];
  dq_pkg::idx_t                     shadow_head = '0;
  dq_pkg::cnt_t                     shadow_count = '0;

  // Driver staging state.
  deque_request_t staged_req;
  bit             staged = 1'b0;
  int unsigned    idle_left = 0;

  double_ended_queue_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .push_value   (push_value),
    .result_valid (result_valid),
    .result_value (result_value),
    .no_item      (no_item),
    .push_dropped (push_dropped)
  );

  // Clock and reset.
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic dq_pkg::idx_t tail_slot();
    return dq_pkg::idx_t'((int'(shadow_head) + int'(shadow_count) - 1) % dq_pkg::DEPTH);
  endfunction

  // Applies one request to the shadow deque and queues the result word it yields.
  task automatic apply_deque_op(input logic [dq_pkg::OP_W-1:0] code,
                                input logic signed [dq_pkg::DATA_W-1:0] word);
    deque_result_t res;
    res = '{value: '0, no_item: 1'b0, push_dropped: 1'b0};
    case (code)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (int'(shadow_count) >= dq_pkg::DEPTH) begin
          res.push_dropped = 1'b1;
        end else if (code == dq_pkg::OP_PUSH_FRONT) begin
          shadow_head = dq_pkg::idx_t'((int'(shadow_head) + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH);
          shadow_store[shadow_head] = word;
          shadow_count = shadow_count + 1'b1;
        end else begin
          shadow_count = shadow_count + 1'b1;
          shadow_store[tail_slot()] = word;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_FRONT: begin
        if (shadow_count == 0) begin
          res.no_item = 1'b1;
        end else begin
          res.value = shadow_store[shadow_head];
          if (code == dq_pkg::OP_POP_FRONT) begin
            shadow_head = dq_pkg::idx_t'((int'(shadow_head) + 1) % dq_pkg::DEPTH);
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_BACK: begin
        if (shadow_count == 0) begin
          res.no_item = 1'b1;
        end else begin
          res.value = shadow_store[tail_slot()];
          if (code == dq_pkg::OP_POP_BACK) begin
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      dq_pkg::OP_SIZE: begin
        res.value = dq_pkg::DATA_W'(shadow_count);
      end
      default: begin
        res.value = (shadow_count == 0) ? 32'sd1 : 32'sd0;
      end
    endcase
    expected_results.insert(expected_results.size(), res);
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_request(input logic [dq_pkg::OP_W-1:0] code,
                             input logic signed [dq_pkg::DATA_W-1:0] word,
                             input bit quiet, input bit settle);
    deque_request_t req;
    req.code = code;
    req.word = word;
    req.gap = pick_gap(quiet);
    req.settle = settle;
    request_queue.insert(request_queue.size(), req);
  endtask

  // Request list: directed opening, then random traffic in fill, full and drain phases.
  initial begin
    int level;
    int phase;
    int full_left;
    bit quiet;
    int unsigned roll;
    logic [dq_pkg::OP_W-1:0] code;

    // Empty deque: every query and every pop or peek.
    add_request(dq_pkg::OP_SIZE,       32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_EMPTY,      32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_POP_FRONT,  32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_POP_BACK,   32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_FRONT,      32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_BACK,       32'sd0, 1'b0, 1'b0);
    // Extreme words at both ends; the first front push wraps the head.
    add_request(dq_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, 1'b0);
    add_request(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 1'b1, 1'b0);
    add_request(dq_pkg::OP_PUSH_BACK,  -32'sd1, 1'b0, 1'b0);
    add_request(dq_pkg::OP_PUSH_FRONT, 32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_FRONT,      32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_BACK,       32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_SIZE,       32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_EMPTY,      32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_POP_BACK,   32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_POP_FRONT,  32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_POP_FRONT,  32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_POP_BACK,   32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_EMPTY,      32'sd0, 1'b0, 1'b0);
    add_request(dq_pkg::OP_PUSH_FRONT, 32'sh5555_5555, 1'b1, 1'b0);
    add_request(dq_pkg::OP_BACK,       32'sd0, 1'b1, 1'b0);
    add_request(dq_pkg::OP_POP_FRONT,  32'sd0, 1'b0, 1'b0);

    // Phases: 0 mixed, 1 fill, 2 held full, 3 drain.
    level = 0;
    phase = 0;
    full_left = 0;
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      case (phase)
        1: code = (roll < 90) ? dq_pkg::OP_W'($urandom_range(0, 1))
                              : dq_pkg::OP_W'($urandom_range(2, 7));
        3: code = (roll < 88) ? dq_pkg::OP_W'($urandom_range(2, 3))
                              : dq_pkg::OP_W'($urandom_range(0, 7));
        default: code = dq_pkg::OP_W'($urandom_range(0, 7));
      endcase
      add_request(code, $urandom, quiet, (n % 400 == 0));
      if ((code == dq_pkg::OP_PUSH_FRONT || code == dq_pkg::OP_PUSH_BACK) &&
          level < dq_pkg::DEPTH) level++;
      if ((code == dq_pkg::OP_POP_FRONT || code == dq_pkg::OP_POP_BACK) && level > 0) level--;
      // Phase changes follow the tracked fill level.
      if (phase == 0 && n >= 150) begin
        phase = 1;
      end else if (phase == 1 && level == dq_pkg::DEPTH) begin
        phase = 2;
        full_left = 40;
      end else if (phase == 2) begin
        full_left--;
        if (full_left == 0) phase = 3;
      end else if (phase == 3 && level == 0) begin
        phase = 0;
      end
    end
  end

  // Driver: one request word per accept, with gaps and an occasional full drain.
  always @(posedge clk) begin
    bit fire;
    fire = start && !busy;
    if (rst) begin
      start <= 1'b0;
      op <= dq_pkg::OP_SIZE;
      push_value <= '0;
    end else begin
      if (fire) begin
        apply_deque_op(op, push_value);
      end
      if (fire || !start) begin
        if (!staged && request_queue.size() != 0 &&
            !(request_queue[0].settle && expected_results.size() != 0)) begin
          staged_req = request_queue[0];
          request_queue.delete(0);
          staged = 1'b1;
          idle_left = staged_req.gap;
        end
        if (staged && idle_left == 0) begin
          start <= 1'b1;
          op <= staged_req.code;
          push_value <= staged_req.word;
          staged = 1'b0;
        end else begin
          start <= 1'b0;
          if (staged) idle_left--;
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input deque_result_t want,
                               input deque_result_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH %s at %0t: expected value=%0d no_item=%0b dropped=%0b,",
               what, $realtime, want.value, want.no_item, want.push_dropped);
      $display("  got value=%0d no_item=%0b dropped=%0b",
               got.value, got.no_item, got.push_dropped);
    end
    mismatch_count++;
  endtask

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && result_valid) begin
      got = '{value: result_value, no_item: no_item, push_dropped: push_dropped};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got.value !== want.value) note_mismatch("result_value", want, got);
        if (got.no_item !== want.no_item) note_mismatch("no_item", want, got);
        if (got.push_dropped !== want.push_dropped) note_mismatch("push_dropped", want, got);
      end
    end
  end

  // End of run: wait until all requests are sent and all results are back.
  initial begin
    @(negedge rst);
    while (request_queue.size() != 0 || staged || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
